// ===== design/kgd_pkg.sv =====
package kgd_pkg;

  localparam int unsigned NUM_KEYS_DEF = 2;
  localparam int unsigned PIN_W        = 2;
  localparam int unsigned FLAG_W       = 7;
  localparam int unsigned TIMER_W      = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DBL_WINDOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DBL_TIMEOUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TIME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LVLS  = 3'd5;

  // event flag bits
  localparam logic [FLAG_W-1:0] EV_PRESSING = 7'h01;
  localparam logic [FLAG_W-1:0] EV_DOWN     = 7'h02;
  localparam logic [FLAG_W-1:0] EV_UP       = 7'h04;
  localparam logic [FLAG_W-1:0] EV_CLICK    = 7'h08;
  localparam logic [FLAG_W-1:0] EV_DOUBLE   = 7'h10;
  localparam logic [FLAG_W-1:0] EV_LONG     = 7'h20;
  localparam logic [FLAG_W-1:0] EV_REPEAT   = 7'h40;

  typedef enum logic [2:0] {
    KEY_FREE     = 3'd0,
    KEY_PRESSED  = 3'd1,
    KEY_RELEASED = 3'd2,
    KEY_WAIT2    = 3'd3,
    KEY_LONG     = 3'd4
  } key_state_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_TICK,
    CTL_QUERY,
    CTL_DONE
  } ctl_state_e;

  typedef struct packed {
    logic               action;
    logic [PIN_W-1:0]   pin_levels;
    logic               key_id;
    logic [FLAG_W-1:0]  event_mask;
  } kgd_in_t;

  typedef struct packed {
    logic               hit;
    logic [FLAG_W-1:0]  key_flags;
  } kgd_out_t;

  // one memory word per key; all zero is the reset state
  typedef struct packed {
    logic [TIMER_W-1:0] timer;
    key_state_e         fsm;
    logic               pressed_now;
    logic               pressed_before;
    logic [FLAG_W-1:0]  flags;
  } key_entry_t;

  typedef struct packed {
    logic [TIMER_W-1:0] long_press_time;
    logic [TIMER_W-1:0] dbl_window;
    logic [TIMER_W-1:0] dbl_timeout;
    logic [TIMER_W-1:0] repeat_time;
  } kgd_times_t;

endpackage

// ===== design/key_gesture_detector_top.sv =====
// A tick item walks every key in CTL_TICK, a query handles one key in CTL_QUERY; both
// then pass CTL_DONE, and the next item is taken only back in CTL_IDLE. The key
// state memory is visited one key per cycle through its single read and write port.
// A finished result waits in the output register while the next item is processed.
// Reset clears control state and loads the configuration defaults; per-key valid bits make
// every entry read as the free, unpressed, zero-flag state until written, so no clearing pass.
module key_gesture_detector_top #(
  parameter int unsigned NUM_KEYS = kgd_pkg::NUM_KEYS_DEF,
  localparam int unsigned ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kgd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kgd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  kgd_pkg::kgd_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output kgd_pkg::kgd_out_t                  out_data_o
);

  localparam int unsigned ENTRY_W = $bits(kgd_pkg::key_entry_t);

  // configuration
  logic [7:0]                      scan_period_q;
  kgd_pkg::kgd_times_t             times_q;
  logic [kgd_pkg::PIN_W-1:0]       trig_q;

  // control
  kgd_pkg::ctl_state_e             state_q, state_d;
  logic [7:0]                      scan_count_q;
  logic [7:0]                      scan_count_inc;
  logic                            scan_q;
  logic                            in_range_q;
  logic [ADDR_W-1:0]               idx_q;
  logic [NUM_KEYS-1:0]             valid_q;
  logic                            rd_vld_q;
  logic                            out_valid_q;
  logic                            accept;
  logic                            last_key;
  logic                            out_free;

  // payload
  kgd_pkg::kgd_in_t                item_q;
  kgd_pkg::kgd_out_t               res_q;
  kgd_pkg::kgd_out_t               out_q;
  kgd_pkg::kgd_out_t               qres;

  // memory side
  logic                            ram_we;
  logic [ADDR_W-1:0]               ram_waddr;
  logic [ADDR_W-1:0]               ram_raddr;
  logic [ENTRY_W-1:0]              ram_wdata;
  logic [ENTRY_W-1:0]              ram_rdata;
  kgd_pkg::key_entry_t             cur_entry;
  kgd_pkg::key_entry_t             scan_entry;
  kgd_pkg::key_entry_t             query_entry;
  logic                            key_active;
  logic                            pin_bit;
  logic                            trig_bit;
  logic                            query_wr;

  assign accept         = in_valid_i && in_ready_o;
  assign out_free       = !out_valid_q || out_ready_i;
  assign last_key       = (idx_q == ADDR_W'(NUM_KEYS - 1));
  assign scan_count_inc = scan_count_q + 8'd1;

  // keys past the pin field see level 0 and trigger 0
  assign pin_bit    = (32'(idx_q) < 32'(kgd_pkg::PIN_W)) && item_q.pin_levels[idx_q[0]];
  assign trig_bit   = (32'(idx_q) < 32'(kgd_pkg::PIN_W)) && trig_q[idx_q[0]];
  assign key_active = (pin_bit == trig_bit);

  assign cur_entry = rd_vld_q ? kgd_pkg::key_entry_t'(ram_rdata) : '0;

  kgd_key_scan u_scan (
    .entry_i   (cur_entry),
    .pressed_i (key_active),
    .scan_en_i (scan_q),
    .times_i   (times_q),
    .entry_o   (scan_entry)
  );

  always_comb begin
    qres           = '0;
    query_entry    = cur_entry;
    query_wr       = 1'b0;
    if (in_range_q) begin
      qres.key_flags = cur_entry.flags;
      qres.hit       = (cur_entry.flags & item_q.event_mask) != '0;
      query_wr       = qres.hit && (item_q.event_mask != kgd_pkg::EV_PRESSING);
    end
    query_entry.flags = cur_entry.flags & ~item_q.event_mask;
  end

  kgd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_KEYS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kgd_pkg::CTL_IDLE: begin
        if (accept) begin
          state_d = in_data_i.action ? kgd_pkg::CTL_QUERY : kgd_pkg::CTL_TICK;
        end
      end
      kgd_pkg::CTL_TICK: begin
        if (last_key) begin
          state_d = kgd_pkg::CTL_DONE;
        end
      end
      kgd_pkg::CTL_QUERY: begin
        state_d = kgd_pkg::CTL_DONE;
      end
      kgd_pkg::CTL_DONE: begin
        if (out_free) begin
          state_d = kgd_pkg::CTL_IDLE;
        end
      end
      default: begin
        state_d = kgd_pkg::CTL_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = scan_entry;
    ram_raddr  = idx_q;
    unique case (state_q)
      kgd_pkg::CTL_IDLE: begin
        in_ready_o = 1'b1;
        ram_raddr  = in_data_i.action ? ADDR_W'(in_data_i.key_id) : '0;
      end
      kgd_pkg::CTL_TICK: begin
        ram_we    = 1'b1;
        ram_raddr = idx_q + 1'b1;
      end
      kgd_pkg::CTL_QUERY: begin
        ram_we    = query_wr;
        ram_wdata = query_entry;
      end
      kgd_pkg::CTL_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q                 <= kgd_pkg::CTL_IDLE;
      scan_count_q            <= '0;
      scan_q                  <= 1'b0;
      in_range_q              <= 1'b0;
      idx_q                   <= '0;
      valid_q                 <= '0;
      rd_vld_q                <= 1'b0;
      out_valid_q             <= 1'b0;
      scan_period_q           <= 8'd20;
      times_q.long_press_time <= 16'd1000;
      times_q.dbl_window      <= 16'd200;
      times_q.dbl_timeout     <= 16'd1000;
      times_q.repeat_time     <= 16'd100;
      trig_q                  <= 2'd1;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= valid_q[ram_raddr];
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (accept) begin
        idx_q      <= in_data_i.action ? ADDR_W'(in_data_i.key_id) : '0;
        in_range_q <= 32'(in_data_i.key_id) < 32'(NUM_KEYS);
        scan_q     <= 1'b0;
        if (!in_data_i.action) begin
          // scan when the incremented count reaches or passes the period
          if (scan_count_inc >= scan_period_q) begin
            scan_count_q <= '0;
            scan_q       <= 1'b1;
          end else begin
            scan_count_q <= scan_count_inc;
          end
        end
      end else if (state_q == kgd_pkg::CTL_TICK) begin
        idx_q <= idx_q + 1'b1;
      end
      if (state_q == kgd_pkg::CTL_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          kgd_pkg::CFG_SCAN_PERIOD:  scan_period_q           <= cfg_wdata_i[7:0];
          kgd_pkg::CFG_LONG_PRESS:   times_q.long_press_time <= cfg_wdata_i;
          kgd_pkg::CFG_DBL_WINDOW:   times_q.dbl_window      <= cfg_wdata_i;
          kgd_pkg::CFG_DBL_TIMEOUT:  times_q.dbl_timeout     <= cfg_wdata_i;
          kgd_pkg::CFG_REPEAT_TIME:  times_q.repeat_time     <= cfg_wdata_i;
          kgd_pkg::CFG_TRIGGER_LVLS: trig_q                  <= cfg_wdata_i[kgd_pkg::PIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      res_q  <= '0;
    end else if (state_q == kgd_pkg::CTL_QUERY) begin
      res_q <= qres;
    end
    if (state_q == kgd_pkg::CTL_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/kgd_ram.sv =====
module kgd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/kgd_key_scan.sv =====
module kgd_key_scan (
  input  kgd_pkg::key_entry_t entry_i,
  input  logic                pressed_i,
  input  logic                scan_en_i,
  input  kgd_pkg::kgd_times_t times_i,
  output kgd_pkg::key_entry_t entry_o
);

  logic [kgd_pkg::TIMER_W-1:0] timer_dec;

  // count down first, then scan on the decremented value
  assign timer_dec = (entry_i.timer != '0) ? entry_i.timer - 1'b1 : entry_i.timer;

  always_comb begin
    entry_o       = entry_i;
    entry_o.timer = timer_dec;
    if (scan_en_i) begin
      entry_o.pressed_before = entry_i.pressed_now;
      entry_o.pressed_now    = pressed_i;
      if (pressed_i) begin
        entry_o.flags = entry_i.flags | kgd_pkg::EV_PRESSING;
      end else begin
        entry_o.flags = entry_i.flags & ~kgd_pkg::EV_PRESSING;
      end
      if (!entry_i.pressed_now && pressed_i) begin
        entry_o.flags = entry_o.flags | kgd_pkg::EV_DOWN;
      end else if (entry_i.pressed_now && !pressed_i) begin
        entry_o.flags = entry_o.flags | kgd_pkg::EV_UP;
      end

      unique case (entry_i.fsm)
        kgd_pkg::KEY_FREE: begin
          if (pressed_i) begin
            entry_o.timer = times_i.long_press_time;
            entry_o.fsm   = kgd_pkg::KEY_PRESSED;
          end
        end
        kgd_pkg::KEY_PRESSED: begin
          if (!pressed_i) begin
            entry_o.timer = times_i.dbl_window;
            entry_o.fsm   = kgd_pkg::KEY_RELEASED;
          end else if (timer_dec == '0) begin
            entry_o.timer = times_i.repeat_time;
            entry_o.flags = entry_o.flags | kgd_pkg::EV_LONG;
            entry_o.fsm   = kgd_pkg::KEY_LONG;
          end
        end
        kgd_pkg::KEY_RELEASED: begin
          if (pressed_i) begin
            entry_o.timer = times_i.dbl_timeout;
            entry_o.fsm   = kgd_pkg::KEY_WAIT2;
          end else if (timer_dec == '0) begin
            entry_o.flags = entry_o.flags | kgd_pkg::EV_CLICK;
            entry_o.fsm   = kgd_pkg::KEY_FREE;
          end
        end
        kgd_pkg::KEY_LONG: begin
          if (!pressed_i) begin
            entry_o.fsm = kgd_pkg::KEY_FREE;
          end else if (timer_dec == '0) begin
            entry_o.flags = entry_o.flags | kgd_pkg::EV_REPEAT;
            entry_o.timer = times_i.repeat_time;
          end
        end
        kgd_pkg::KEY_WAIT2: begin
          if (!pressed_i) begin
            entry_o.flags = entry_o.flags | kgd_pkg::EV_DOUBLE;
            entry_o.fsm   = kgd_pkg::KEY_FREE;
          end else if (timer_dec == '0) begin
            entry_o.fsm = kgd_pkg::KEY_LONG;
          end
        end
        default: begin
          entry_o.fsm = kgd_pkg::KEY_FREE;
        end
      endcase
    end
  end

endmodule
